FILE: design/fifo_handoff_mutex_unit_defines.svh
// Assertion macros shared by the mutex unit RTL.
`ifndef FIFO_HANDOFF_MUTEX_UNIT_DEFINES_SVH
`define FIFO_HANDOFF_MUTEX_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FHMU_ASSERT(lbl, clk_s, rst_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) \
		else $error("fhmu assertion failed");
`define FHMU_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("fhmu assertion failed");
`else
`define FHMU_ASSERT(lbl, clk_s, rst_s, prop)
`define FHMU_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif

`endif

FILE: design/fhmu_pkg.sv
package fhmu_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int THREAD_BITS_DEF = 8;

	typedef enum logic [1:0] {
		ACT_LOCK   = 2'd0,
		ACT_TRY    = 2'd1,
		ACT_UNLOCK = 2'd2,
		ACT_REMOVE = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		ST_GRANTED  = 4'd0,
		ST_QUEUED   = 4'd1,
		ST_REFUSED  = 4'd2,
		ST_RELEASED = 4'd3,
		ST_HANDOFF  = 4'd4,
		ST_IGNORED  = 4'd5,
		ST_REMOVED  = 4'd6,
		ST_NOTFOUND = 4'd7,
		ST_FULL     = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE = 2'd0,
		S_EXEC = 2'd1,
		S_OUT  = 2'd2
	} state_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_cmd_t;

endpackage

FILE: design/fhmu_ctrl.sv
`include "fifo_handoff_mutex_unit_defines.svh"

module fhmu_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output fhmu_pkg::ctrl_cmd_t  cmd
);

	fhmu_pkg::state_t state_q;
	fhmu_pkg::state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fhmu_pkg::S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n     = state_q;
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		unique case (state_q)
			fhmu_pkg::S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_n = fhmu_pkg::S_EXEC;
				end
			end
			fhmu_pkg::S_EXEC: begin
				cmd.execute = 1'b1;
				state_n     = fhmu_pkg::S_OUT;
			end
			fhmu_pkg::S_OUT: begin
				out_valid = 1'b1;
				// take the next request in the same cycle the result leaves
				in_ready    = out_ready;
				cmd.capture = in_valid && out_ready;
				if (out_ready) begin
					state_n = in_valid ? fhmu_pkg::S_EXEC : fhmu_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = fhmu_pkg::S_IDLE;
			end
		endcase
	end

	`FHMU_ASSERT_NEXT(a_capture_then_exec, clk, arst_n, cmd.capture, cmd.execute)
	`FHMU_ASSERT_NEXT(a_exec_then_result, clk, arst_n, cmd.execute, out_valid)
	`FHMU_ASSERT(a_no_capture_while_stalled, clk, arst_n, !(out_valid && !out_ready && cmd.capture))

endmodule

FILE: design/fhmu_dp.sv
`include "fifo_handoff_mutex_unit_defines.svh"

module fhmu_dp #(
	parameter int QUEUE_DEPTH = fhmu_pkg::QUEUE_DEPTH_DEF,
	parameter int THREAD_BITS = fhmu_pkg::THREAD_BITS_DEF,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  fhmu_pkg::ctrl_cmd_t    cmd,
	input  logic [1:0]             action,
	input  logic [THREAD_BITS-1:0] thread_id,
	output logic [3:0]             status,
	output logic                   woken_valid,
	output logic [THREAD_BITS-1:0] woken_thread,
	output logic                   owner_valid,
	output logic [THREAD_BITS-1:0] owner_thread,
	output logic [CNT_W-1:0]       waiting_count
);

	// architectural state
	logic                   held_q;
	logic [THREAD_BITS-1:0] owner_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [THREAD_BITS-1:0] cells_q [QUEUE_DEPTH];

	// captured request and per-cell match
	fhmu_pkg::action_t      act_s1;
	logic [THREAD_BITS-1:0] tid_s1;
	logic [QUEUE_DEPTH-1:0] match_s1;
	logic [QUEUE_DEPTH-1:0] match_c;

	// result register
	fhmu_pkg::status_t      status_q;
	logic                   woken_v_q;
	logic [THREAD_BITS-1:0] woken_q;

	// execute-step decode
	fhmu_pkg::status_t      status_n;
	logic                   is_owner;
	logic                   grant;
	logic                   enq;
	logic                   release_own;
	logic                   handoff;
	logic                   drop;
	logic [QUEUE_DEPTH-1:0] from_first;
	logic [QUEUE_DEPTH-1:0] shift;

	always_comb begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			match_c[i] = (cells_q[i] == thread_id) && (CNT_W'(i) < cnt_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_s1   <= fhmu_pkg::action_t'(action);
			tid_s1   <= thread_id;
			match_s1 <= match_c;
		end
	end

	always_comb begin
		is_owner    = held_q && (owner_q == tid_s1);
		grant       = 1'b0;
		enq         = 1'b0;
		release_own = 1'b0;
		drop        = 1'b0;
		status_n    = fhmu_pkg::ST_IGNORED;
		unique case (act_s1)
			fhmu_pkg::ACT_LOCK: begin
				if (!held_q) begin
					grant    = 1'b1;
					status_n = fhmu_pkg::ST_GRANTED;
				end else if (cnt_q < CNT_W'(QUEUE_DEPTH)) begin
					enq      = 1'b1;
					status_n = fhmu_pkg::ST_QUEUED;
				end else begin
					status_n = fhmu_pkg::ST_FULL;
				end
			end
			fhmu_pkg::ACT_TRY: begin
				if (!held_q) begin
					grant    = 1'b1;
					status_n = fhmu_pkg::ST_GRANTED;
				end else begin
					status_n = fhmu_pkg::ST_REFUSED;
				end
			end
			fhmu_pkg::ACT_UNLOCK: begin
				release_own = is_owner;
			end
			fhmu_pkg::ACT_REMOVE: begin
				if (!held_q) begin
					status_n = fhmu_pkg::ST_NOTFOUND;
				end else if (is_owner) begin
					release_own = 1'b1;
				end else if (|match_s1) begin
					drop     = 1'b1;
					status_n = fhmu_pkg::ST_REMOVED;
				end else begin
					status_n = fhmu_pkg::ST_NOTFOUND;
				end
			end
			default: begin
				status_n = fhmu_pkg::ST_IGNORED;
			end
		endcase
		handoff = release_own && (cnt_q != '0);
		if (release_own) begin
			status_n = handoff ? fhmu_pkg::ST_HANDOFF : fhmu_pkg::ST_RELEASED;
		end
	end

	// cells at and above the oldest match move down one place
	assign from_first = match_s1 | ~(match_s1 - QUEUE_DEPTH'(1));
	assign shift = handoff ? '1 : (drop ? from_first : '0);

	for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
		if (g < QUEUE_DEPTH - 1) begin : g_mid
			always_ff @(posedge clk) begin
				if (cmd.execute) begin
					if (shift[g]) begin
						cells_q[g] <= cells_q[g+1];
					end else if (enq && (cnt_q == CNT_W'(g))) begin
						cells_q[g] <= tid_s1;
					end
				end
			end
		end else begin : g_last
			always_ff @(posedge clk) begin
				if (cmd.execute && enq && (cnt_q == CNT_W'(g))) begin
					cells_q[g] <= tid_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= 1'b0;
			owner_q <= '0;
			cnt_q   <= '0;
		end else if (cmd.execute) begin
			if (grant) begin
				held_q  <= 1'b1;
				owner_q <= tid_s1;
			end else if (handoff) begin
				owner_q <= cells_q[0];
			end else if (release_own) begin
				held_q  <= 1'b0;
				owner_q <= '0;
			end
			if (enq) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (handoff || drop) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			status_q  <= status_n;
			woken_v_q <= handoff;
			woken_q   <= handoff ? cells_q[0] : '0;
		end
	end

	// owner and count only change on execute, so they stand for the pending result
	assign status        = status_q;
	assign woken_valid   = woken_v_q;
	assign woken_thread  = woken_q;
	assign owner_valid   = held_q;
	assign owner_thread  = owner_q;
	assign waiting_count = cnt_q;

	`FHMU_ASSERT(a_count_bound, clk, arst_n, cnt_q <= CNT_W'(QUEUE_DEPTH))
	`FHMU_ASSERT(a_free_owner_zero, clk, arst_n, held_q || (owner_q == '0))
	`FHMU_ASSERT_NEXT(a_enq_grows, clk, arst_n, cmd.execute && enq, cnt_q == $past(cnt_q) + CNT_W'(1))
	`FHMU_ASSERT_NEXT(a_handoff_owner, clk, arst_n, cmd.execute && handoff, held_q && (owner_q == woken_q))

endmodule

FILE: design/fifo_handoff_mutex_unit.sv
// Hardware mutex with a first-in first-out wait queue.
// Request channel (in_valid/in_ready): action and thread_id. Lock grants a free
// mutex or queues the caller, try-lock grants or refuses, unlock by the owner
// hands off to the oldest waiter or frees the mutex, remove drops the owner
// (as an unlock) or the oldest matching waiter and compacts the queue.
// Result channel (out_valid/out_ready): one transfer per request with status,
// the woken thread on handoff, and owner and waiter count after the request.
// An accepted request is captured, then executed, which registers the result,
// and the result is then held on the result channel until taken. The next request
// is taken in the cycle its predecessor's result leaves, not before; the limit is
// the capture/execute sequence of the controller, where capture registers the
// per-cell match against the request.
// While the receiver stalls, the result holds and no request is accepted.
// Reset (arst_n low) frees the mutex and empties the queue; no clearing pass
// is needed and a request may be sent in the first cycle after reset.
module fifo_handoff_mutex_unit #(
	parameter int QUEUE_DEPTH = fhmu_pkg::QUEUE_DEPTH_DEF,
	parameter int THREAD_BITS = fhmu_pkg::THREAD_BITS_DEF,
	parameter int CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             action,
	input  logic [THREAD_BITS-1:0] thread_id,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [3:0]             status,
	output logic                   woken_valid,
	output logic [THREAD_BITS-1:0] woken_thread,
	output logic                   owner_valid,
	output logic [THREAD_BITS-1:0] owner_thread,
	output logic [CNT_W-1:0]       waiting_count
);

	fhmu_pkg::ctrl_cmd_t cmd;

	fhmu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	fhmu_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.THREAD_BITS (THREAD_BITS),
		.CNT_W       (CNT_W)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.action        (action),
		.thread_id     (thread_id),
		.status        (status),
		.woken_valid   (woken_valid),
		.woken_thread  (woken_thread),
		.owner_valid   (owner_valid),
		.owner_thread  (owner_thread),
		.waiting_count (waiting_count)
	);

endmodule

FILE: tb/fifo_handoff_mutex_unit_test.sv
`timescale 1ns / 1ps

module fifo_handoff_mutex_unit_test;

	localparam int TID_W        = fhmu_pkg::THREAD_BITS_DEF;
	localparam int WAIT_SLOTS   = fhmu_pkg::QUEUE_DEPTH_DEF;
	localparam int CNT_W        = $clog2(fhmu_pkg::QUEUE_DEPTH_DEF + 1);
	localparam int RANDOM_ITEMS = 1724;
	localparam int QUIET_TAIL   = 300;
	localparam int LONG_HOLD    = 80;

	typedef struct packed {
		fhmu_pkg::status_t status;
		logic              woken_valid;
		logic [TID_W-1:0]  woken_thread;
		logic              owner_valid;
		logic [TID_W-1:0]  owner_thread;
		logic [CNT_W-1:0]  waiting_count;
	} mutex_result_t;

	// Shadow of the lock: owner, FIFO of waiters and the answers still owed.
	class mutex_scoreboard;
		bit               held;
		logic [TID_W-1:0] owner;
		logic [TID_W-1:0] waiters[$];
		mutex_result_t    expected[$];
		int               errors;

		// owner leaves: pass the lock to the oldest waiter, or free it
		function fhmu_pkg::status_t hand_off(output logic woke,
				output logic [TID_W-1:0] woken);
			woke  = 1'b0;
			woken = '0;
			if (waiters.size() != 0) begin
				woken = waiters.pop_front();
				woke  = 1'b1;
				owner = woken;
				return fhmu_pkg::ST_HANDOFF;
			end
			held  = 1'b0;
			owner = '0;
			return fhmu_pkg::ST_RELEASED;
		endfunction

		function void note_request(fhmu_pkg::action_t act, logic [TID_W-1:0] tid);
			mutex_result_t    res;
			logic             woke;
			logic [TID_W-1:0] woken;
			int               pos;
			woke  = 1'b0;
			woken = '0;
			pos   = -1;
			case (act)
				fhmu_pkg::ACT_LOCK: begin
					if (!held) begin
						held       = 1'b1;
						owner      = tid;
						res.status = fhmu_pkg::ST_GRANTED;
					end else if (waiters.size() < WAIT_SLOTS) begin
						waiters.push_back(tid);
						res.status = fhmu_pkg::ST_QUEUED;
					end else begin
						res.status = fhmu_pkg::ST_FULL;
					end
				end
				fhmu_pkg::ACT_TRY: begin
					if (!held) begin
						held       = 1'b1;
						owner      = tid;
						res.status = fhmu_pkg::ST_GRANTED;
					end else begin
						res.status = fhmu_pkg::ST_REFUSED;
					end
				end
				fhmu_pkg::ACT_UNLOCK: begin
					if (held && owner == tid)
						res.status = hand_off(woke, woken);
					else
						res.status = fhmu_pkg::ST_IGNORED;
				end
				default: begin
					if (!held) begin
						res.status = fhmu_pkg::ST_NOTFOUND;
					end else if (owner == tid) begin
						res.status = hand_off(woke, woken);
					end else begin
						// drop only the oldest matching waiter
						foreach (waiters[k])
							if (pos < 0 && waiters[k] == tid)
								pos = k;
						if (pos >= 0) begin
							waiters.delete(pos);
							res.status = fhmu_pkg::ST_REMOVED;
						end else begin
							res.status = fhmu_pkg::ST_NOTFOUND;
						end
					end
				end
			endcase
			res.woken_valid   = woke;
			res.woken_thread  = woke ? woken : '0;
			res.owner_valid   = held;
			res.owner_thread  = held ? owner : '0;
			res.waiting_count = CNT_W'(waiters.size());
			expected.push_back(res);
		endfunction

		function void compare_field(string name, logic [TID_W-1:0] exp, logic [TID_W-1:0] got);
			if (got !== exp) begin
				$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp, got);
				errors++;
			end
		endfunction

		function void check_result(logic [3:0] st, logic wv, logic [TID_W-1:0] wt,
				logic ov, logic [TID_W-1:0] ot, logic [CNT_W-1:0] cnt);
			mutex_result_t res;
			if (expected.size() == 0) begin
				$display("%0t: result transfer with nothing expected: expected none, actual status %0d",
					$time, st);
				errors++;
				return;
			end
			res = expected.pop_front();
			compare_field("status", res.status, st);
			compare_field("woken_valid", res.woken_valid, wv);
			compare_field("woken_thread", res.woken_thread, wt);
			compare_field("owner_valid", res.owner_valid, ov);
			compare_field("owner_thread", res.owner_thread, ot);
			compare_field("waiting_count", res.waiting_count, cnt);
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [1:0]       action;
	logic [TID_W-1:0] thread_id;
	logic             out_valid;
	logic             out_ready;
	logic [3:0]       status;
	logic             woken_valid;
	logic [TID_W-1:0] woken_thread;
	logic             owner_valid;
	logic [TID_W-1:0] owner_thread;
	logic [CNT_W-1:0] waiting_count;

	mutex_scoreboard sb;
	int              tx_idle_pct;
	int              rx_stall_pct;
	bit              hold_request;

	fifo_handoff_mutex_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.thread_id     (thread_id),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.woken_valid   (woken_valid),
		.woken_thread  (woken_thread),
		.owner_valid   (owner_valid),
		.owner_thread  (owner_thread),
		.waiting_count (waiting_count)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("FAIL fifo_handoff_mutex_unit");
		$finish;
	end

	// result side: random stall bursts, plus a long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		out_ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD;
			end
			if (!arst_n) begin
				out_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct)
					stall_left = $urandom_range(1, 9);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, woken_valid, woken_thread, owner_valid, owner_thread,
				waiting_count);

	task automatic send_request(input fhmu_pkg::action_t act, input logic [TID_W-1:0] tid);
		int gap;
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid  <= 1'b1;
		action    <= act;
		thread_id <= tid;
		do @(posedge clk); while (!in_ready);
		sb.note_request(act, tid);
	endtask

	// hold the request side until every answer is back
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [TID_W-1:0] pick_thread();
		if ($urandom_range(0, 9) < 7)
			return TID_W'($urandom_range(0, 7));
		return TID_W'($urandom_range(0, (1 << TID_W) - 1));
	endfunction

	// mostly well-formed traffic: unlocks by the owner, removals of real waiters
	function automatic void next_random(input int lock_weight, output fhmu_pkg::action_t act,
			output logic [TID_W-1:0] tid);
		int r;
		int pick;
		r    = $urandom_range(0, 99);
		pick = $urandom_range(0, 9);
		tid  = pick_thread();
		if (r < lock_weight) begin
			act = fhmu_pkg::ACT_LOCK;
		end else if (r < lock_weight + 10) begin
			act = fhmu_pkg::ACT_TRY;
		end else if (r < lock_weight + 10 + (90 - lock_weight) / 2) begin
			act = fhmu_pkg::ACT_UNLOCK;
			if (sb.held && pick < 8)
				tid = sb.owner;
		end else begin
			act = fhmu_pkg::ACT_REMOVE;
			if (sb.waiters.size() != 0 && pick < 6)
				tid = sb.waiters[$urandom_range(0, sb.waiters.size() - 1)];
			else if (sb.held && pick < 8)
				tid = sb.owner;
		end
	endfunction

	task automatic run_directed();
		logic [TID_W-1:0] fill_ids [16] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd2, 8'd4,
			8'd8, 8'd16, 8'd32, 8'd64, 8'd128, 8'hAA, 8'h55, 8'd255, 8'd3};
		send_request(fhmu_pkg::ACT_UNLOCK, 8'd0);     // free lock: ignored
		send_request(fhmu_pkg::ACT_REMOVE, 8'd255);   // free lock: not found
		send_request(fhmu_pkg::ACT_TRY, 8'd0);
		// owner and duplicates queue like anyone else
		foreach (fill_ids[k])
			send_request(fhmu_pkg::ACT_LOCK, fill_ids[k]);
		send_request(fhmu_pkg::ACT_LOCK, 8'd7);       // queue full
		send_request(fhmu_pkg::ACT_TRY, 8'd255);
		send_request(fhmu_pkg::ACT_UNLOCK, 8'd255);   // not the owner
		send_request(fhmu_pkg::ACT_REMOVE, 8'h77);
		send_request(fhmu_pkg::ACT_REMOVE, 8'd255);   // oldest match only
		send_request(fhmu_pkg::ACT_UNLOCK, 8'd0);
		send_request(fhmu_pkg::ACT_REMOVE, 8'd0);     // owner removed: handoff
	endtask

	initial begin
		fhmu_pkg::action_t act;
		logic [TID_W-1:0]  tid;
		int                lock_weight;
		int                levels [4];
		levels       = '{0, 10, 30, 60};
		sb           = new();
		arst_n       = 1'b0;
		in_valid    <= 1'b0;
		action      <= fhmu_pkg::ACT_LOCK;
		thread_id   <= '0;
		hold_request = 1'b0;
		tx_idle_pct  = 20;
		rx_stall_pct = 20;
		lock_weight  = 65;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		wait_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 200 == 0) begin
				// alternate filling and draining so the queue sweeps empty to full
				lock_weight  = ((i / 200) % 2 == 0) ? 65 : 25;
				tx_idle_pct  = levels[$urandom_range(0, 3)];
				rx_stall_pct = levels[$urandom_range(0, 3)];
			end
			if (i >= RANDOM_ITEMS - QUIET_TAIL) begin
				tx_idle_pct  = 0;
				rx_stall_pct = 0;
			end
			if (i == 300 || i == 1100)
				hold_request = 1'b1;
			if (i == 700)
				wait_drained();
			next_random(lock_weight, act, tid);
			send_request(act, tid);
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("PASS fifo_handoff_mutex_unit");
		else
			$display("FAIL fifo_handoff_mutex_unit");
		$finish;
	end

endmodule
